>>> rtl/core/sird_pkg.sv
// shared types, constants and helper functions for the radix digit converter
package sird_pkg;

   localparam int NUMBER_W       = 32;
   localparam int RADIX_W        = 5;
   localparam int SYMBOLS_W      = 64;
   localparam int CHAR_W         = 8;
   localparam int DIGIT_W        = 4;
   localparam int MAX_ALPHABET   = 16;
   localparam int ALPHABET_W     = MAX_ALPHABET * CHAR_W;
   localparam int CSR_INDEX_W    = 2;

   localparam int BITS_PER_CYCLE = 8;
   localparam int DIV_CYCLES     = NUMBER_W / BITS_PER_CYCLE;
   localparam int STEP_W         = $clog2(DIV_CYCLES);
   localparam int MAX_DIGITS     = 32;
   localparam int DIGIT_IDX_W    = $clog2(MAX_DIGITS);

   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_W-1:0] SYM_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] SYM_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] SYM_NUL   = 8'h00;

   localparam logic [CSR_INDEX_W-1:0] CSR_RADIX        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOLS_LOW  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOLS_HIGH = 2'd2;

   // one classified item waiting for conversion
   typedef struct packed {
      logic                neg;
      logic [NUMBER_W-1:0] mag;
   } item_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_SIGN,
      BK_EMIT
   } bk_state_type;

   function automatic logic [CHAR_W-1:0] symbol_of(
      input logic [ALPHABET_W-1:0] alphabet,
      input logic [DIGIT_W-1:0]    digit
   );
      return alphabet[{digit, 3'b000} +: CHAR_W];
   endfunction

   // radix in range, no reserved byte and no duplicate among the used symbols
   function automatic logic alphabet_ok(
      input logic [RADIX_W-1:0]    radix,
      input logic [ALPHABET_W-1:0] alphabet,
      input int                    max_symbols
   );
      logic              ok;
      logic [CHAR_W-1:0] s;
      ok = (radix >= RADIX_W'(2)) && (int'(radix) <= max_symbols)
           && (radix <= RADIX_W'(MAX_ALPHABET));
      for (int i = 0; i < MAX_ALPHABET; i++) begin
         s = alphabet[i*CHAR_W +: CHAR_W];
         if (RADIX_W'(i) < radix) begin
            if (s == SYM_NUL || s == SYM_PLUS || s == SYM_MINUS) begin
               ok = 1'b0;
            end
            for (int j = i + 1; j < MAX_ALPHABET; j++) begin
               if (RADIX_W'(j) < radix && alphabet[j*CHAR_W +: CHAR_W] == s) begin
                  ok = 1'b0;
               end
            end
         end
      end
      return ok;
   endfunction

endpackage

>>> rtl/core/sird_queue.sv
// short fifo of classified items between the front and back parts
module sird_queue import sird_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type pop_item
);

   item_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue push while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue pop while empty");

endmodule

>>> rtl/core/sird_front.sv
// front part: takes a number, checks the alphabet, splits sign and magnitude
module sird_front import sird_pkg::*; #(
   parameter int MAX_SYMBOLS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [NUMBER_W-1:0] req_number,
   input  logic [RADIX_W-1:0]         radix,
   input  logic [ALPHABET_W-1:0]      alphabet,
   input  logic                       queue_full,
   output logic                       push,
   output item_type                   push_item
);

   logic                slot_full_ff, slot_full_in;
   item_type            slot_item_ff, slot_item_in;
   logic                accept;
   logic                alpha_ok;
   logic [NUMBER_W-1:0] raw;

   assign busy      = slot_full_ff && queue_full;
   assign accept    = start && !busy;
   assign push      = slot_full_ff && !queue_full;
   assign push_item = slot_item_ff;
   assign alpha_ok  = alphabet_ok(radix, alphabet, MAX_SYMBOLS);
   assign raw       = unsigned'(req_number);

   always_comb begin
      slot_item_in.neg = raw[NUMBER_W-1];
      slot_item_in.mag = raw[NUMBER_W-1] ? (NUMBER_W'(0) - raw) : raw;
      slot_full_in     = slot_full_ff;
      if (accept && alpha_ok) begin
         slot_full_in = 1'b1;
      end else if (push) begin
         slot_full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_full_ff <= 1'b0;
      end else begin
         slot_full_ff <= slot_full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && alpha_ok) begin
         slot_item_ff <= slot_item_in;
      end
   end

   a_bad_alphabet_dropped: assert property (@(posedge clock) disable iff (reset)
      (accept && !alpha_ok) |=> !slot_full_ff)
      else $error("item with bad alphabet was kept");

endmodule

>>> rtl/core/sird_back.sv
// back part: shared divider builds digits, then characters go out msd first
module sird_back import sird_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [RADIX_W-1:0]    radix,
   input  logic [ALPHABET_W-1:0] alphabet,
   input  logic                  queue_empty,
   input  item_type              queue_item,
   output logic                  pop,
   output logic                  rsp_strobe,
   output logic [CHAR_W-1:0]     rsp_character,
   output logic                  rsp_last
);

   bk_state_type           state_ff, state_in;
   logic [NUMBER_W-1:0]    work_ff, work_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [DIGIT_IDX_W-1:0] count_ff, count_in;
   logic                   neg_ff, neg_in;
   logic [DIGIT_W-1:0]     digits_ff [MAX_DIGITS];

   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [CHAR_W-1:0]      rsp_character_ff, rsp_character_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [NUMBER_W-1:0]    div_work;
   logic [DIGIT_W-1:0]     div_rem;
   logic [DIGIT_W:0]       trial;
   logic                   digit_done;
   logic                   conv_done;

   // eight restoring division steps per cycle on a narrow remainder
   always_comb begin
      div_rem  = rem_ff;
      div_work = work_ff;
      trial    = '0;
      for (int i = 0; i < BITS_PER_CYCLE; i++) begin
         trial    = {div_rem, div_work[NUMBER_W-1]};
         div_work = {div_work[NUMBER_W-2:0], 1'b0};
         if (trial >= radix) begin
            trial       = trial - radix;
            div_work[0] = 1'b1;
         end
         div_rem = trial[DIGIT_W-1:0];
      end
   end

   assign digit_done = (state_ff == BK_DIVIDE) && (step_ff == STEP_W'(DIV_CYCLES - 1));
   assign conv_done  = digit_done
                       && ((div_work == '0) || (count_ff == DIGIT_IDX_W'(MAX_DIGITS - 1)));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               state_in = BK_DIVIDE;
            end
         end
         BK_DIVIDE: begin
            if (conv_done) begin
               state_in = neg_ff ? BK_SIGN : BK_EMIT;
            end
         end
         BK_SIGN: begin
            state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (count_ff == '0) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      pop              = 1'b0;
      work_in          = work_ff;
      rem_in           = rem_ff;
      step_in          = step_ff;
      count_in         = count_ff;
      neg_in           = neg_ff;
      rsp_strobe_in    = 1'b0;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               work_in  = queue_item.mag;
               neg_in   = queue_item.neg;
               rem_in   = '0;
               step_in  = '0;
               count_in = '0;
            end
         end
         BK_DIVIDE: begin
            work_in = div_work;
            rem_in  = div_rem;
            step_in = step_ff + 1'b1;
            if (digit_done) begin
               rem_in  = '0;
               step_in = '0;
               if (!conv_done) begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         BK_SIGN: begin
            rsp_strobe_in    = 1'b1;
            rsp_character_in = SYM_MINUS;
         end
         BK_EMIT: begin
            rsp_strobe_in    = 1'b1;
            rsp_character_in = symbol_of(alphabet, digits_ff[count_ff]);
            rsp_last_in      = (count_ff == '0);
            if (count_ff != '0) begin
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         rsp_strobe_ff <= 1'b0;
         rsp_last_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff          <= work_in;
      rem_ff           <= rem_in;
      step_ff          <= step_in;
      count_ff         <= count_in;
      neg_ff           <= neg_in;
      rsp_character_ff <= rsp_character_in;
      if (digit_done) begin
         digits_ff[count_ff] <= div_rem;
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

   a_sign_then_digits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_SIGN) |=> (state_ff == BK_EMIT))
      else $error("minus sign not followed by digits");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_EMIT && count_ff == '0) |=> (state_ff == BK_IDLE && rsp_last_ff))
      else $error("final digit did not close the item");

endmodule

>>> rtl/core/signed_integer_to_radix_digits.sv
// top level of the signed integer to radix text converter
//
//  channel   ports                                   transfer
//  -------   -------------------------------------   ------------------------------------
//  request   start, busy, req_number                 edge with start high and busy low
//  response  rsp_strobe, rsp_character, rsp_last     every edge with rsp_strobe high
//  csr       csr_write_enable, csr_index, csr_data   every edge with csr_write_enable high
//
//  conversion: the shared divider works out each digit at 8 quotient bits a cycle, then the
//    characters go out msd first, after a minus sign for a negative number
//  the divider in the back part is the slow step; items overlap via the front slot and the queue
//  reset: csr registers clear to zero, queue and front slot empty, back part idle
//  busy rises when the front slot holds an item and the queue is full
//  the receiver cannot stall: each character shows on the rsp ports for one cycle
module signed_integer_to_radix_digits import sird_pkg::*; #(
   parameter int MAX_SYMBOLS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   // request
   input  logic                       start,
   output logic                       busy,
   input  logic signed [NUMBER_W-1:0] req_number,
   // response
   output logic                       rsp_strobe,
   output logic [CHAR_W-1:0]          rsp_character,
   output logic                       rsp_last,
   // csr writes
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [SYMBOLS_W-1:0]       csr_data
);

   // configuration registers
   logic [RADIX_W-1:0]    radix_ff, radix_in;
   logic [SYMBOLS_W-1:0]  symbols_low_ff, symbols_low_in;
   logic [SYMBOLS_W-1:0]  symbols_high_ff, symbols_high_in;
   logic [ALPHABET_W-1:0] alphabet;

   // front to queue to back
   logic     push;
   item_type push_item;
   logic     queue_full;
   logic     queue_empty;
   logic     pop;
   item_type pop_item;

   // csr decode, out-of-range indexes are dropped
   always_comb begin
      radix_in        = radix_ff;
      symbols_low_in  = symbols_low_ff;
      symbols_high_in = symbols_high_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_RADIX:        radix_in        = csr_data[RADIX_W-1:0];
            CSR_SYMBOLS_LOW:  symbols_low_in  = csr_data;
            CSR_SYMBOLS_HIGH: symbols_high_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff        <= '0;
         symbols_low_ff  <= '0;
         symbols_high_ff <= '0;
      end else begin
         radix_ff        <= radix_in;
         symbols_low_ff  <= symbols_low_in;
         symbols_high_ff <= symbols_high_in;
      end
   end

   // digit value 0 sits in the lowest byte
   assign alphabet = {symbols_high_ff, symbols_low_ff};

   // classify: alphabet check, sign and unsigned magnitude
   sird_front #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_number (req_number),
      .radix      (radix_ff),
      .alphabet   (alphabet),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   // decouples acceptance from the slow conversion
   sird_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .pop_item  (pop_item)
   );

   // iterative division, digit stack, character output
   sird_back u_back (
      .clock         (clock),
      .reset         (reset),
      .radix         (radix_ff),
      .alphabet      (alphabet),
      .queue_empty   (queue_empty),
      .queue_item    (pop_item),
      .pop           (pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

>>> tb/tb_signed_integer_to_radix_digits.sv
// testbench for signed_integer_to_radix_digits: directed and random stimulus with a predictor and checker
`timescale 1ns / 1ps

module tb_signed_integer_to_radix_digits;
   import sird_pkg::*;

   localparam int ALPHABET_LIMIT = 16;
   // drain time for the divider, which is slowest in base 2
   localparam int DRAIN_CYCLES   = 200;
   localparam int TIMEOUT_NS     = 1000000;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_ITEMS    = 21;
   // index 3 has no register behind it, writes to it must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } text_char_type;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 start            = 1'b0;
   logic                 busy;
   logic [NUMBER_W-1:0]  req_number       = '0;
   logic                 rsp_strobe;
   logic [CHAR_W-1:0]    rsp_character;
   logic                 rsp_last;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [SYMBOLS_W-1:0] csr_data         = '0;

   // our copy of the csr registers, updated as each write goes out
   logic [RADIX_W-1:0]   cfg_radix        = '0;
   logic [SYMBOLS_W-1:0] cfg_symbols_low  = '0;
   logic [SYMBOLS_W-1:0] cfg_symbols_high = '0;

   logic [NUMBER_W-1:0]  numbers_to_send[$];
   text_char_type        expected_chars[$];

   // no idle bursts from the sender once this is set
   bit quiet     = 1'b0;
   int idle_left = 0;

   int errors          = 0;
   int numbers_sent    = 0;
   int numbers_silent  = 0;
   int chars_checked   = 0;
   int settings_used   = 0;

   signed_integer_to_radix_digits #(
      .MAX_SYMBOLS (ALPHABET_LIMIT)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_number       (req_number),
      .rsp_strobe       (rsp_strobe),
      .rsp_character    (rsp_character),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // text of one number under the current alphabet, queued as expected characters
   function automatic void convert_number(input logic [NUMBER_W-1:0] num);
      logic [ALPHABET_W-1:0] alph;
      logic [CHAR_W-1:0]     sym;
      logic                  ok;
      logic                  neg;
      logic [NUMBER_W-1:0]   mag;
      logic [NUMBER_W-1:0]   base;
      logic [DIGIT_W-1:0]    digits[MAX_DIGITS];
      int                    nd;
      alph = {cfg_symbols_high, cfg_symbols_low};
      ok   = (cfg_radix >= 2) && (int'(cfg_radix) <= ALPHABET_LIMIT)
             && (int'(cfg_radix) <= MAX_ALPHABET);
      // only the used symbols are screened: no reserved byte, no repeat
      if (ok) begin
         for (int i = 0; i < int'(cfg_radix); i++) begin
            sym = alph[i*CHAR_W +: CHAR_W];
            if (sym == SYM_NUL || sym == SYM_PLUS || sym == SYM_MINUS) ok = 1'b0;
            for (int j = i + 1; j < int'(cfg_radix); j++)
               if (alph[j*CHAR_W +: CHAR_W] == sym) ok = 1'b0;
         end
      end
      if (!ok) begin
         numbers_silent++;
         return;
      end
      neg  = num[NUMBER_W-1];
      // magnitude as unsigned, so the most negative value converts too
      mag  = neg ? (~num + 1'b1) : num;
      base = NUMBER_W'(cfg_radix);
      nd   = 0;
      do begin
         digits[nd] = DIGIT_W'(mag % base);
         mag        = mag / base;
         nd++;
      end while (mag != 0 && nd < MAX_DIGITS);
      if (neg) expected_chars.push_back('{ch: SYM_MINUS, last: 1'b0});
      for (int k = nd - 1; k >= 0; k--)
         expected_chars.push_back('{ch: alph[int'(digits[k])*CHAR_W +: CHAR_W],
                                    last: (k == 0)});
   endfunction

   function automatic logic [ALPHABET_W-1:0] pack_text(input string s);
      logic [ALPHABET_W-1:0] a;
      a = '0;
      for (int i = 0; i < s.len() && i < MAX_ALPHABET; i++) a[i*CHAR_W +: CHAR_W] = s[i];
      return a;
   endfunction

   // n distinct legal symbols, the unused bytes anything at all
   function automatic logic [ALPHABET_W-1:0] random_alphabet(input int n);
      logic [ALPHABET_W-1:0] a;
      bit                    taken[256];
      logic [CHAR_W-1:0]     b;
      taken = '{default: 1'b0};
      for (int i = 0; i < MAX_ALPHABET; i++) begin
         if (i < n) begin
            do b = CHAR_W'($urandom_range(1, 255));
            while (taken[b] || b == SYM_PLUS || b == SYM_MINUS);
            taken[b] = 1'b1;
         end else begin
            b = CHAR_W'($urandom_range(0, 255));
         end
         a[i*CHAR_W +: CHAR_W] = b;
      end
      return a;
   endfunction

   // small values, powers of two and extremes get more weight than their share
   function automatic logic [NUMBER_W-1:0] pick_number();
      logic [NUMBER_W-1:0] v;
      int                  sel;
      sel = $urandom_range(0, 4);
      case (sel)
         0: v = NUMBER_W'($urandom_range(0, 40));
         1: v = NUMBER_W'(1) << $urandom_range(0, NUMBER_W - 1);
         2: begin
            case ($urandom_range(0, 3))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'hFFFF_FFFF;
               default: v = 32'h8000_0001;
            endcase
         end
         default: v = $urandom;
      endcase
      if (sel < 2 && $urandom_range(0, 1) == 1) v = ~v + 1'b1;
      return v;
   endfunction

   // wait for the sender and the checker to run dry, then let the divider finish
   task automatic settle();
      @(negedge clock);
      while (numbers_to_send.size() != 0 || start || expected_chars.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [SYMBOLS_W-1:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= val;
      case (idx)
         CSR_RADIX:        cfg_radix        = val[RADIX_W-1:0];
         CSR_SYMBOLS_LOW:  cfg_symbols_low  = val;
         CSR_SYMBOLS_HIGH: cfg_symbols_high = val;
         default: ;
      endcase
   endtask

   // new alphabet, only written with nothing in flight
   task automatic set_alphabet(input logic [SYMBOLS_W-1:0] radix_word,
                               input logic [ALPHABET_W-1:0] alph);
      settle();
      write_reg(CSR_RADIX, radix_word);
      write_reg(CSR_SYMBOLS_LOW, alph[SYMBOLS_W-1:0]);
      write_reg(CSR_SYMBOLS_HIGH, alph[ALPHABET_W-1:SYMBOLS_W]);
      write_reg(CSR_UNUSED, {$urandom, $urandom});
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      settings_used++;
   endtask

   // driver: one number per transfer, random idle bursts between them
   always @(posedge clock) begin
      if (reset) begin
         start     <= 1'b0;
         idle_left <= 0;
      end else if (!start || !busy) begin
         // a transfer just happened, predict its text
         if (start) begin
            convert_number(req_number);
            numbers_sent++;
         end
         if (idle_left != 0) begin
            idle_left <= idle_left - 1;
            start     <= 1'b0;
         end else if (numbers_to_send.size() != 0 && !quiet && $urandom_range(0, 3) == 0) begin
            // this cycle starts the idle burst, idle_left holds what remains of it
            idle_left <= $urandom_range(0, 8);
            start     <= 1'b0;
         end else if (numbers_to_send.size() != 0) begin
            start      <= 1'b1;
            req_number <= numbers_to_send.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobe is one character, checked against the oldest expectation
   always @(posedge clock) begin : check_chars
      text_char_type want;
      if (!reset && rsp_strobe) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected character, expected none, got char %h last %b",
                     $time, rsp_character, rsp_last);
            errors++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_character !== want.ch) begin
               $display("%0t: character mismatch, expected %h, got %h",
                        $time, want.ch, rsp_character);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last flag mismatch, expected %b, got %b",
                        $time, want.last, rsp_last);
               errors++;
            end
            chars_checked++;
         end
      end
   end

   initial begin
      logic [ALPHABET_W-1:0] alph;
      logic [SYMBOLS_W-1:0]  radix_word;
      int                    n;
      int                    k;
      int                    j;
      int                    count;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // registers at reset: radix zero, so nothing comes out
      numbers_to_send.push_back(32'd5);
      numbers_to_send.push_back(32'h8000_0000);

      // decimal: zero, ones, both extremes, sign around a carry
      set_alphabet(64'd10, pack_text("0123456789"));
      numbers_to_send.push_back(32'd0);
      numbers_to_send.push_back(32'd1);
      numbers_to_send.push_back(32'hFFFF_FFFF);
      numbers_to_send.push_back(32'h7FFF_FFFF);
      numbers_to_send.push_back(32'h8000_0000);
      numbers_to_send.push_back(32'd10);
      numbers_to_send.push_back(-32'd10);
      numbers_to_send.push_back(32'd1000000007);

      // widest alphabet
      set_alphabet(64'd16, pack_text("0123456789abcdef"));
      numbers_to_send.push_back(32'hFFFF_FFFF);
      numbers_to_send.push_back(32'h7FFF_FFFF);
      numbers_to_send.push_back(32'h8000_0000);
      numbers_to_send.push_back(32'd0);

      // narrowest alphabet: 33 characters for the most negative value
      set_alphabet(64'd2, pack_text("01"));
      numbers_to_send.push_back(32'h8000_0000);
      numbers_to_send.push_back(32'h7FFF_FFFF);
      numbers_to_send.push_back(32'hFFFF_FFFF);

      // invalid settings, each must swallow the number
      set_alphabet(64'd1, pack_text("0"));
      numbers_to_send.push_back(32'd7);
      // radix 17 in the low bits, junk above that the register drops
      set_alphabet(64'hFFFF_FFFF_FFFF_FFF1, pack_text("0123456789abcdefg"));
      numbers_to_send.push_back(32'd7);
      set_alphabet(64'd3, pack_text("0+2"));
      numbers_to_send.push_back(32'd7);
      set_alphabet(64'd3, pack_text("-01"));
      numbers_to_send.push_back(32'd7);
      // third used symbol is a zero byte
      set_alphabet(64'd3, pack_text("01"));
      numbers_to_send.push_back(32'd7);
      set_alphabet(64'd4, pack_text("0120"));
      numbers_to_send.push_back(32'd7);
      // reserved bytes past the radix do not matter
      set_alphabet(64'd3, pack_text("xyz-+"));
      numbers_to_send.push_back(-32'd5);
      numbers_to_send.push_back(32'd26);

      // random alphabets, narrowest first and widest last; two broken ones between
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) n = 2;
         else if (p == RANDOM_PHASES - 1) n = MAX_ALPHABET;
         else n = $urandom_range(2, MAX_ALPHABET);
         alph       = random_alphabet(n);
         radix_word = {$urandom, 27'($urandom), 5'(n)};
         count      = PHASE_ITEMS;
         if (p == 4 || p == 8) begin
            count = 8;
            k     = $urandom_range(0, n - 1);
            case ($urandom_range(0, 2))
               0: begin
                  case ($urandom_range(0, 2))
                     0: alph[k*CHAR_W +: CHAR_W] = SYM_PLUS;
                     1: alph[k*CHAR_W +: CHAR_W] = SYM_MINUS;
                     default: alph[k*CHAR_W +: CHAR_W] = SYM_NUL;
                  endcase
               end
               1: begin
                  j = (k + 1 + $urandom_range(0, n - 2)) % n;
                  alph[j*CHAR_W +: CHAR_W] = alph[k*CHAR_W +: CHAR_W];
               end
               default: begin
                  radix_word[RADIX_W-1:0] = ($urandom_range(0, 1) == 1)
                     ? RADIX_W'($urandom_range(0, 1)) : RADIX_W'($urandom_range(17, 31));
               end
            endcase
         end
         set_alphabet(radix_word, alph);
         // the last stretch runs back to back
         if (p == RANDOM_PHASES - 1) quiet = 1'b1;
         repeat (count) numbers_to_send.push_back(pick_number());
      end

      settle();
      $display("converted %0d numbers under %0d alphabet settings, radix 2 to 16 and invalid",
               numbers_sent, settings_used);
      $display("checked %0d characters, %0d numbers rightly gave no text",
               chars_checked, numbers_silent);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // hang guard
   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d characters still expected", expected_chars.size());
      $display("Mismatches found");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/sird_pkg.sv
rtl/core/sird_queue.sv
rtl/core/sird_front.sv
rtl/core/sird_back.sv
rtl/core/signed_integer_to_radix_digits.sv
tb/tb_signed_integer_to_radix_digits.sv
